[rtl/rld_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rld_pkg
// Shared types, codes and reset constants of the raster line run decoder.
// ----------------------------------------------------------------------------
package rld_pkg;

	localparam int unsigned MAX_LINE_UNITS_DEF = 8192;
	localparam int unsigned QUEUE_DEPTH        = 4;
	localparam int unsigned CFG_DATA_W         = 16;
	localparam int unsigned CFG_INDEX_W        = 2;

	localparam logic [2:0]  UNIT_BYTES_RST = 3'd3;
	localparam logic [13:0] LINE_UNITS_RST = 14'd8192;
	localparam logic [15:0] PAGE_ROWS_RST  = 16'hffff;
	localparam logic        URF_MODE_RST   = 1'b0;

	localparam logic [7:0]  CODE_WHITE     = 8'd128;
	localparam logic [8:0]  CODE_VERB_BASE = 9'd257;
	localparam logic [31:0] WHITE_TWO      = 32'h0000_ffff;
	localparam logic [31:0] WHITE_THREE    = 32'h00ff_ffff;

	typedef enum logic [1:0] {
		CFG_UNIT_BYTES = 2'd0,
		CFG_LINE_UNITS = 2'd1,
		CFG_PAGE_ROWS  = 2'd2,
		CFG_URF_MODE   = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		PH_REPEAT   = 2'd0,
		PH_CODE     = 2'd1,
		PH_RUN_UNIT = 2'd2,
		PH_VERBATIM = 2'd3
	} phase_t;

	// effective configuration as seen by the front end
	typedef struct packed {
		logic [2:0]  unit_bytes;
		logic [13:0] line_units;
		logic        urf_mode;
		logic        rows_reload;
		logic [15:0] rows_value;
	} cfg_t;

	// one decoded command: an optional pixel run, then an optional line end
	typedef struct packed {
		logic        has_run;
		logic        has_end;
		logic [31:0] unit_value;
		logic [12:0] start_unit;
		logic [13:0] run_length;
		logic        run_overrun;
		logic [8:0]  line_copies;
		logic        end_overrun;
		logic        page_done;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage
`default_nettype wire

[rtl/rld_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rld_front
// Accepts stream bytes, tracks line and page state, builds decode commands.
// ----------------------------------------------------------------------------
module rld_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire rld_pkg::cfg_t cfg,
	input  wire logic          code_valid,
	output logic               code_ready,
	input  wire logic [7:0]    code_byte,
	input  wire logic          q_full,
	output logic               push,
	output rld_pkg::cmd_t      cmd
);

	rld_pkg::phase_t phase_q, phase_d;
	logic [1:0]  byte_in_unit_q;
	logic [31:0] unit_accum_q;
	logic [7:0]  units_left_q;
	logic [13:0] line_position_q;
	logic [7:0]  pending_repeat_q;
	logic [15:0] rows_left_q;

	logic        accept;
	logic        in_unit;
	logic        is_white;
	logic        unit_done;
	logic [31:0] accum_next;
	logic [13:0] room;
	logic [13:0] run_n;
	logic [13:0] run_len;
	logic        run_ovr;
	logic [13:0] pos_after_run;
	logic [7:0]  units_after;
	logic        fire_run;
	logic        fire_end;
	logic [8:0]  copies_raw;
	logic        copies_clip;
	logic [8:0]  copies;
	logic [15:0] rows_after;
	logic [31:0] white_value;

	assign code_ready = !q_full;
	assign accept     = code_valid && code_ready;

	assign in_unit    = (phase_q == rld_pkg::PH_RUN_UNIT) || (phase_q == rld_pkg::PH_VERBATIM);
	assign is_white   = cfg.urf_mode && (code_byte == rld_pkg::CODE_WHITE);
	assign unit_done  = (({1'b0, byte_in_unit_q} + 3'd1) >= cfg.unit_bytes);
	assign accum_next = {unit_accum_q[23:0], code_byte};

	assign room = (line_position_q < cfg.line_units) ? (cfg.line_units - line_position_q) : 14'd0;

	always_comb begin
		run_n = 14'd1;
		if (phase_q == rld_pkg::PH_CODE) begin
			run_n = room;
		end else if (phase_q == rld_pkg::PH_RUN_UNIT) begin
			run_n = {6'd0, units_left_q};
		end
	end

	assign run_len       = (run_n < room) ? run_n : room;
	assign run_ovr       = (run_n > room);
	assign pos_after_run = line_position_q + run_len;
	assign units_after   = (phase_q == rld_pkg::PH_RUN_UNIT) ? 8'd0 : (units_left_q - 8'd1);

	assign fire_run = ((phase_q == rld_pkg::PH_CODE) && is_white) || (in_unit && unit_done);
	assign fire_end = ((phase_q == rld_pkg::PH_CODE) && is_white)
		|| (in_unit && unit_done && (units_after == 8'd0) && (pos_after_run >= cfg.line_units));

	// clip copies to the rows still open in the page
	assign copies_raw  = {1'b0, pending_repeat_q} + 9'd1;
	assign copies_clip = ({7'd0, copies_raw} > rows_left_q);
	assign copies      = copies_clip ? rows_left_q[8:0] : copies_raw;
	assign rows_after  = rows_left_q - {7'd0, copies};

	always_comb begin
		case (cfg.unit_bytes)
			3'd2:    white_value = rld_pkg::WHITE_TWO;
			3'd3:    white_value = rld_pkg::WHITE_THREE;
			default: white_value = 32'd0;
		endcase
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			rld_pkg::PH_REPEAT: begin
				phase_d = rld_pkg::PH_CODE;
			end
			rld_pkg::PH_CODE: begin
				if (is_white) begin
					phase_d = rld_pkg::PH_REPEAT;
				end else if (code_byte < rld_pkg::CODE_WHITE) begin
					phase_d = rld_pkg::PH_RUN_UNIT;
				end else begin
					phase_d = rld_pkg::PH_VERBATIM;
				end
			end
			rld_pkg::PH_RUN_UNIT, rld_pkg::PH_VERBATIM: begin
				if (unit_done && (units_after == 8'd0)) begin
					phase_d = fire_end ? rld_pkg::PH_REPEAT : rld_pkg::PH_CODE;
				end
			end
			default: phase_d = rld_pkg::PH_REPEAT;
		endcase
	end

	// command to the queue
	always_comb begin
		push            = accept && (fire_run || fire_end);
		cmd.has_run     = fire_run;
		cmd.has_end     = fire_end;
		cmd.unit_value  = (phase_q == rld_pkg::PH_CODE) ? white_value : accum_next;
		cmd.start_unit  = (run_len != 14'd0) ? line_position_q[12:0] : 13'd0;
		cmd.run_length  = run_len;
		cmd.run_overrun = run_ovr;
		cmd.line_copies = copies;
		cmd.end_overrun = copies_clip;
		cmd.page_done   = (rows_after == 16'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= rld_pkg::PH_REPEAT;
			byte_in_unit_q   <= 2'd0;
			unit_accum_q     <= 32'd0;
			units_left_q     <= 8'd0;
			line_position_q  <= 14'd0;
			pending_repeat_q <= 8'd0;
			rows_left_q      <= rld_pkg::PAGE_ROWS_RST;
		end else begin
			if (cfg.rows_reload) begin
				rows_left_q <= cfg.rows_value;
			end
			if (accept) begin
				phase_q <= phase_d;
				if (phase_q == rld_pkg::PH_REPEAT) begin
					pending_repeat_q <= code_byte;
				end
				if (phase_q == rld_pkg::PH_CODE) begin
					byte_in_unit_q <= 2'd0;
					unit_accum_q   <= 32'd0;
					if (!is_white) begin
						units_left_q <= (code_byte < rld_pkg::CODE_WHITE)
							? (code_byte + 8'd1)
							: 8'(rld_pkg::CODE_VERB_BASE - {1'b0, code_byte});
					end
				end
				if (in_unit) begin
					if (unit_done) begin
						byte_in_unit_q <= 2'd0;
						unit_accum_q   <= 32'd0;
						units_left_q   <= units_after;
					end else begin
						byte_in_unit_q <= byte_in_unit_q + 2'd1;
						unit_accum_q   <= accum_next;
					end
				end
				if (fire_run) begin
					line_position_q <= pos_after_run;
				end
				// line end: rewind the line, count rows, reload at page end
				if (fire_end) begin
					line_position_q  <= 14'd0;
					pending_repeat_q <= 8'd0;
					rows_left_q      <= (rows_after == 16'd0) ? cfg.rows_value : rows_after;
				end
			end
		end
	end

endmodule
`default_nettype wire

[rtl/rld_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rld_fifo
// Short command queue between the decode front end and the result back end.
// ----------------------------------------------------------------------------
module rld_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire rld_pkg::cmd_t  cmd_in,
	input  wire logic           pop,
	output rld_pkg::cmd_t       head,
	output rld_pkg::q_status_t  status
);

	localparam int unsigned PTR_W = (rld_pkg::QUEUE_DEPTH > 1) ? $clog2(rld_pkg::QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(rld_pkg::QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(rld_pkg::QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(rld_pkg::QUEUE_DEPTH);

	rld_pkg::cmd_t    mem_q [rld_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign status.full  = (count_q == CNT_FULL);
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : (wr_ptr_q + PTR_W'(1));
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : (rd_ptr_q + PTR_W'(1));
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

[rtl/rld_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rld_back
// Expands queued commands into result items in a registered output stage.
// ----------------------------------------------------------------------------
module rld_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rld_pkg::cmd_t      head,
	input  wire rld_pkg::q_status_t status,
	output logic                    pop,
	input  wire logic               res_ready,
	output logic                    res_valid,
	output logic                    kind,
	output logic [31:0]             unit_value,
	output logic [12:0]             start_unit,
	output logic [13:0]             run_length,
	output logic [8:0]              line_copies,
	output logic                    overrun,
	output logic                    page_done,
	output logic                    last
);

	logic res_valid_q;
	logic run_sent_q;
	logic load;
	logic send_run;

	assign res_valid = res_valid_q;
	assign load      = !res_valid_q || res_ready;
	assign send_run  = head.has_run && !run_sent_q;
	// drop the command once its final item is loaded into the output stage
	assign pop       = load && !status.empty && (!send_run || !head.has_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			run_sent_q  <= 1'b0;
		end else if (load) begin
			res_valid_q <= !status.empty;
			if (!status.empty) begin
				run_sent_q <= send_run && head.has_end;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !status.empty) begin
			if (send_run) begin
				kind        <= 1'b0;
				unit_value  <= head.unit_value;
				start_unit  <= head.start_unit;
				run_length  <= head.run_length;
				line_copies <= 9'd0;
				overrun     <= head.run_overrun;
				page_done   <= 1'b0;
				last        <= !head.has_end;
			end else begin
				kind        <= 1'b1;
				unit_value  <= 32'd0;
				start_unit  <= 13'd0;
				run_length  <= 14'd0;
				line_copies <= head.line_copies;
				overrun     <= head.end_overrun;
				page_done   <= head.page_done;
				last        <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/raster_line_run_decoder.sv]
`default_nettype none
// Path: accepted byte -> command queue -> registered output stage.
// Throughput: one byte per cycle while the queue is not full; a byte that causes a run
//   and a line end gives two result items, absorbed by the four-entry command queue.
// Reset: control and row state cleared at once, configuration to its defaults,
//   rows left loaded with the default page height; no clearing pass.
// ----------------------------------------------------------------------------
// raster_line_run_decoder
// Run-length raster decoder emitting pixel runs and line-end items.
// ----------------------------------------------------------------------------
module raster_line_run_decoder #(
	parameter int unsigned MAX_LINE_UNITS = rld_pkg::MAX_LINE_UNITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [rld_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [rld_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            code_valid,
	output logic                                 code_ready,
	input  wire logic [7:0]                      code_byte,
	output logic                                 res_valid,
	input  wire logic                            res_ready,
	output logic                                 kind,
	output logic [31:0]                          unit_value,
	output logic [12:0]                          start_unit,
	output logic [13:0]                          run_length,
	output logic [8:0]                           line_copies,
	output logic                                 overrun,
	output logic                                 page_done,
	output logic                                 last
);

	// Configuration registers, raw as written
	logic [2:0]  unit_bytes_q;
	logic [13:0] line_units_q;
	logic [15:0] page_rows_q;
	logic        urf_mode_q;

	rld_pkg::cfg_t      cfg;
	rld_pkg::cmd_t      cmd;
	rld_pkg::cmd_t      head;
	rld_pkg::q_status_t q_status;
	logic               push;
	logic               pop;
	logic               rows_write;
	logic [15:0]        rows_src;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_bytes_q <= rld_pkg::UNIT_BYTES_RST;
			line_units_q <= rld_pkg::LINE_UNITS_RST;
			page_rows_q  <= rld_pkg::PAGE_ROWS_RST;
			urf_mode_q   <= rld_pkg::URF_MODE_RST;
		end else if (cfg_we) begin
			unique case (rld_pkg::cfg_index_t'(cfg_index))
				rld_pkg::CFG_UNIT_BYTES: unit_bytes_q <= cfg_data[2:0];
				rld_pkg::CFG_LINE_UNITS: line_units_q <= cfg_data[13:0];
				rld_pkg::CFG_PAGE_ROWS:  page_rows_q  <= cfg_data[15:0];
				rld_pkg::CFG_URF_MODE:   urf_mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// A page height write restarts the row count from the written value (zero as one)
	assign rows_write = cfg_we && (rld_pkg::cfg_index_t'(cfg_index) == rld_pkg::CFG_PAGE_ROWS);
	assign rows_src   = rows_write ? cfg_data[15:0] : page_rows_q;

	// Clamp the raw registers into their working ranges
	always_comb begin
		if (unit_bytes_q == 3'd0) begin
			cfg.unit_bytes = 3'd1;
		end else if (unit_bytes_q > 3'd4) begin
			cfg.unit_bytes = 3'd4;
		end else begin
			cfg.unit_bytes = unit_bytes_q;
		end
		if (line_units_q == 14'd0) begin
			cfg.line_units = 14'd1;
		end else if (32'(line_units_q) > MAX_LINE_UNITS) begin
			cfg.line_units = 14'(MAX_LINE_UNITS);
		end else begin
			cfg.line_units = line_units_q;
		end
		cfg.urf_mode    = urf_mode_q;
		cfg.rows_reload = rows_write;
		cfg.rows_value  = (rows_src == 16'd0) ? 16'd1 : rows_src;
	end

	// Front end: classify bytes, keep line and page state
	rld_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.code_valid (code_valid),
		.code_ready (code_ready),
		.code_byte  (code_byte),
		.q_full     (q_status.full),
		.push       (push),
		.cmd        (cmd)
	);

	// Queue: lets the front keep taking bytes while results wait
	rld_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.cmd_in (cmd),
		.pop    (pop),
		.head   (head),
		.status (q_status)
	);

	// Back end: one result item per cycle from the queue head while the result side is ready
	rld_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.status      (q_status),
		.pop         (pop),
		.res_ready   (res_ready),
		.res_valid   (res_valid),
		.kind        (kind),
		.unit_value  (unit_value),
		.start_unit  (start_unit),
		.run_length  (run_length),
		.line_copies (line_copies),
		.overrun     (overrun),
		.page_done   (page_done),
		.last        (last)
	);

	// A line end always closes its byte's results
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind |-> last)
		else $error("line end item without last");

	// A run that is not last is followed at once by its line end
	a_run_then_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !kind && !last |=> res_valid && kind)
		else $error("run without last not followed by line end");

	// An empty run carries no start position
	a_empty_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (run_length == 14'd0) |-> (start_unit == 13'd0))
		else $error("empty run with nonzero start");

endmodule
`default_nettype wire
